// ===== sv/fkhs_pkg.sv =====
`timescale 1ns / 1ps
// fkhs_pkg: widths, constants and shared types of the flow key hash steering unit
// no dependencies; imported by every other file of the block

package fkhs_pkg;

   // field widths
   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int HASH_W = 32;
   localparam int WC_W   = 5;
   localparam int WIDX_W = 4;

   // steering limits
   localparam int MAX_WORKERS = 16;

   // hash constants
   localparam int HASH_MULT = 13;
   localparam int SH_K1     = 24;
   localparam int SH_K2     = 18;
   localparam int SH_K3     = 12;
   localparam int SH_K4     = 6;

   // back end: remainder pipeline
   localparam int BACK_STAGES    = 4;
   localparam int BITS_PER_STAGE = HASH_W / BACK_STAGES;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ADDR_W-1:0] low_addr;
      logic [PORT_W-1:0] low_port;
      logic [ADDR_W-1:0] high_addr;
      logic [PORT_W-1:0] high_port;
   } key_type;

   typedef struct packed {
      key_type           key;
      logic [HASH_W-1:0] flow_hash;
   } entry_type;

endpackage

// ===== sv/fkhs_req_if.sv =====
`timescale 1ns / 1ps
// fkhs_req_if: request channel, two endpoints of one packet header
// depends on fkhs_pkg

interface fkhs_req_if import fkhs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] addr_a;
   logic [PORT_W-1:0] port_a;
   logic [ADDR_W-1:0] addr_b;
   logic [PORT_W-1:0] port_b;

   modport source (output valid, addr_a, port_a, addr_b, port_b, input ready);
   modport sink   (input valid, addr_a, port_a, addr_b, port_b, output ready);
endinterface

// ===== sv/fkhs_rsp_if.sv =====
`timescale 1ns / 1ps
// fkhs_rsp_if: response channel, ordered flow key, hash and chosen worker
// depends on fkhs_pkg

interface fkhs_rsp_if import fkhs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] low_addr;
   logic [PORT_W-1:0] low_port;
   logic [ADDR_W-1:0] high_addr;
   logic [PORT_W-1:0] high_port;
   logic [HASH_W-1:0] flow_hash;
   logic [WIDX_W-1:0] worker_index;

   modport source (output valid, low_addr, low_port, high_addr, high_port, flow_hash,
                   worker_index, input ready);
   modport sink   (input valid, low_addr, low_port, high_addr, high_port, flow_hash,
                   worker_index, output ready);
endinterface

// ===== sv/fkhs_front.sv =====
`timescale 1ns / 1ps
// fkhs_front: takes requests, orders the endpoints, hashes the ordered key
// depends on fkhs_pkg and fkhs_req_if

module fkhs_front import fkhs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fkhs_req_if.sink   req_chan,
   output logic       push_valid,
   input  logic       push_ready,
   output entry_type  push_entry
);

   logic          vld_ff;
   logic          vld_in;
   key_type       key_ff;
   key_type       key_in;
   logic          a_first;
   logic          take;
   logic [7:0]    k1, k2, k3, k4, k5, k8, k9, k10, k11;
   logic [HASH_W-1:0] mix;
   logic [HASH_W-1:0] tail;
   logic [HASH_W-1:0] prod;

   assign req_chan.ready = !vld_ff || push_ready;
   assign take = req_chan.valid && req_chan.ready;

   // lower raw address first, ties broken on host-order port
   always_comb begin
      if (req_chan.addr_a < req_chan.addr_b) begin
         a_first = 1'b1;
      end else if (req_chan.addr_a > req_chan.addr_b) begin
         a_first = 1'b0;
      end else begin
         a_first = {req_chan.port_a[7:0], req_chan.port_a[15:8]} <
                   {req_chan.port_b[7:0], req_chan.port_b[15:8]};
      end
      if (a_first) begin
         key_in.low_addr  = req_chan.addr_a;
         key_in.low_port  = req_chan.port_a;
         key_in.high_addr = req_chan.addr_b;
         key_in.high_port = req_chan.port_b;
      end else begin
         key_in.low_addr  = req_chan.addr_b;
         key_in.low_port  = req_chan.port_b;
         key_in.high_addr = req_chan.addr_a;
         key_in.high_port = req_chan.port_a;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff <= key_in;
      end
   end

   // key bytes in little-endian layout
   assign k1  = key_ff.low_addr[15:8];
   assign k2  = key_ff.low_addr[23:16];
   assign k3  = key_ff.low_addr[31:24];
   assign k4  = key_ff.low_port[7:0];
   assign k5  = key_ff.low_port[15:8];
   assign k8  = key_ff.high_addr[23:16];
   assign k9  = key_ff.high_addr[31:24];
   assign k10 = key_ff.high_port[7:0];
   assign k11 = key_ff.high_port[15:8];

   assign mix  = (HASH_W'(k1) << SH_K1) ^ (HASH_W'(k2) << SH_K2) ^
                 (HASH_W'(k3) << SH_K3) ^ (HASH_W'(k4) << SH_K4) ^ HASH_W'(k5);
   assign tail = {k8, k9, k10, k11};
   assign prod = HASH_W'(mix * HASH_W'(HASH_MULT));

   assign push_valid           = vld_ff;
   assign push_entry.key       = key_ff;
   assign push_entry.flow_hash = prod ^ tail;

   a_key_ordered: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> key_ff.low_addr <= key_ff.high_addr)
      else $error("flow key endpoints out of order");

endmodule

// ===== sv/fkhs_queue.sv =====
`timescale 1ns / 1ps
// fkhs_queue: short queue between front and back end
// depends on fkhs_pkg

module fkhs_queue import fkhs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  entry_type  push_entry,
   output logic       pop_valid,
   input  logic       pop_ready,
   output entry_type  pop_entry
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = cnt_ff < QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// ===== sv/fkhs_back.sv =====
`timescale 1ns / 1ps
// fkhs_back: remainder pipeline for the worker index and the response register
// depends on fkhs_pkg and fkhs_rsp_if

module fkhs_back import fkhs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [WC_W-1:0]  n_eff,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  entry_type        pop_entry,
   fkhs_rsp_if.source       rsp_chan
);

   localparam int LAST = BACK_STAGES - 1;

   typedef struct packed {
      entry_type         item;
      logic [WC_W-1:0]   divisor;
      logic [WIDX_W-1:0] rem;
   } stage_type;

   logic [BACK_STAGES-1:0] vld_ff;
   logic [BACK_STAGES-1:0] vld_in;
   logic [BACK_STAGES-1:0] adv;
   stage_type              stage_ff [BACK_STAGES];
   stage_type              stage_in [BACK_STAGES];

   // restoring remainder over a slice of hash bits, msb first
   function automatic logic [WIDX_W-1:0] rem_step(
      input logic [WIDX_W-1:0]         r,
      input logic [BITS_PER_STAGE-1:0] bits,
      input logic [WC_W-1:0]           n
   );
      logic [WIDX_W:0]   t;
      logic [WIDX_W-1:0] acc;
      acc = r;
      for (int i = BITS_PER_STAGE - 1; i >= 0; i--) begin
         t = {acc, bits[i]};
         if (t >= (WIDX_W + 1)'(n)) begin
            t = t - (WIDX_W + 1)'(n);
         end
         acc = t[WIDX_W-1:0];
      end
      return acc;
   endfunction

   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_chan.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign pop_ready = adv[0];

   always_comb begin
      stage_in[0].item    = pop_entry;
      stage_in[0].divisor = n_eff;
      stage_in[0].rem     = rem_step('0, pop_entry.flow_hash[HASH_W-1 -: BITS_PER_STAGE],
                                     n_eff);
      vld_in[0]           = adv[0] ? pop_valid : vld_ff[0];
      for (int k = 1; k < BACK_STAGES; k++) begin
         stage_in[k].item    = stage_ff[k-1].item;
         stage_in[k].divisor = stage_ff[k-1].divisor;
         stage_in[k].rem     = rem_step(stage_ff[k-1].rem,
            stage_ff[k-1].item.flow_hash[HASH_W-1-k*BITS_PER_STAGE -: BITS_PER_STAGE],
            stage_ff[k-1].divisor);
         vld_in[k]           = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BACK_STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign rsp_chan.valid        = vld_ff[LAST];
   assign rsp_chan.low_addr     = stage_ff[LAST].item.key.low_addr;
   assign rsp_chan.low_port     = stage_ff[LAST].item.key.low_port;
   assign rsp_chan.high_addr    = stage_ff[LAST].item.key.high_addr;
   assign rsp_chan.high_port    = stage_ff[LAST].item.key.high_port;
   assign rsp_chan.flow_hash    = stage_ff[LAST].item.flow_hash;
   assign rsp_chan.worker_index = stage_ff[LAST].rem;

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> WC_W'(stage_ff[LAST].rem) < stage_ff[LAST].divisor)
      else $error("worker index not below worker count");

   a_rem_full: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && stage_ff[LAST].divisor == WC_W'(MAX_WORKERS)) |->
      stage_ff[LAST].rem == stage_ff[LAST].item.flow_hash[WIDX_W-1:0])
      else $error("worker index wrong for full worker count");

endmodule

// ===== sv/flow_key_hash_steer_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake           payload
// req_chan  in   valid/ready         addr_a, port_a, addr_b, port_b
// rsp_chan  out  valid/ready         low/high addr+port, flow_hash, worker_index
// csr       in   csr_wr_en, no wait  csr_wr_data = worker_count (5 bits)
//
// one request per cycle sustained while rsp_chan.ready stays high; a response passes through
// the front register, the queue slot and the four remainder stages in that order
// reset (synchronous, active high) empties every stage and sets worker_count to 1
// a stalled response holds the back end; the two-slot queue lets the front keep taking
// requests until it fills, then req_chan.ready drops
// depends on fkhs_pkg, fkhs_req_if, fkhs_rsp_if, fkhs_front, fkhs_queue, fkhs_back

module flow_key_hash_steer_unit import fkhs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   fkhs_req_if.sink         req_chan,
   fkhs_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [WC_W-1:0]  csr_wr_data
);

   logic [WC_W-1:0] worker_count_ff;
   logic [WC_W-1:0] worker_count_in;
   logic [WC_W-1:0] n_eff;

   // front to queue
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // queue to back
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // worker count register, written whenever the enable is high
   assign worker_count_in = csr_wr_en ? csr_wr_data : worker_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= WC_W'(1);
      end else begin
         worker_count_ff <= worker_count_in;
      end
   end

   // zero acts as one worker, large counts saturate
   always_comb begin
      if (worker_count_ff == '0) begin
         n_eff = WC_W'(1);
      end else if (int'(worker_count_ff) > MAX_WORKERS) begin
         n_eff = WC_W'(MAX_WORKERS);
      end else begin
         n_eff = worker_count_ff;
      end
   end

   // ordering and hash
   fkhs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue
   fkhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // worker selection and response register
   fkhs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .n_eff     (n_eff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== tb/tb_flow_key_hash_steer_unit.sv =====
`timescale 1ns / 1ps
// tb_flow_key_hash_steer_unit: self-checking bench for the flow key hash steering unit
// depends on fkhs_pkg, fkhs_req_if, fkhs_rsp_if and flow_key_hash_steer_unit

module tb_flow_key_hash_steer_unit;
   import fkhs_pkg::*;

   localparam int CLK_HALF_NS   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 10;
   localparam int GAP_PERCENT   = 14;
   localparam int STALL_CYCLES  = 400;
   localparam int SWEEP_ITEMS   = 110;
   localparam int BURST_ITEMS   = 400;
   localparam int STALL_ITEMS   = 250;
   localparam longint RUN_LIMIT_NS = 64'd5_000_000;

   // one request as the bench builds it
   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [PORT_W-1:0] port_a;
      logic [ADDR_W-1:0] addr_b;
      logic [PORT_W-1:0] port_b;
   } flow_request_type;

   // one response as the bench expects it
   typedef struct packed {
      key_type           key;
      logic [HASH_W-1:0] flow_hash;
      logic [WIDX_W-1:0] worker_index;
   } steer_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [WC_W-1:0]  csr_wr_data = '0;

   fkhs_req_if req_chan ();
   fkhs_rsp_if rsp_chan ();

   flow_key_hash_steer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // bench copy of the worker count register, reset value 1
   logic [WC_W-1:0] worker_count_shadow = WC_W'(1);

   steer_result_type expected_steer_q[$];

   int unsigned error_count     = 0;
   int unsigned requests_sent   = 0;
   int unsigned responses_seen  = 0;
   int unsigned count_writes    = 0;
   int unsigned tie_requests    = 0;

   bit gaps_on     = 1'b1;    // random idling on both channels
   bit stall_start = 1'b0;    // asks the receiver for one long hold-off

   always #CLK_HALF_NS clock = ~clock;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // orders the endpoints, hashes the key and picks the worker
   function automatic steer_result_type predict_steering(input flow_request_type r,
                                                         input logic [WC_W-1:0] wc);
      steer_result_type res;
      logic             a_first;
      logic [31:0]      mix;
      logic [31:0]      tail;
      int unsigned      n;
      // lower raw address first; on a tie compare ports in host byte order
      if (r.addr_a != r.addr_b)
         a_first = r.addr_a < r.addr_b;
      else
         a_first = {r.port_a[7:0], r.port_a[15:8]} < {r.port_b[7:0], r.port_b[15:8]};
      if (a_first) begin
         res.key.low_addr  = r.addr_a;
         res.key.low_port  = r.port_a;
         res.key.high_addr = r.addr_b;
         res.key.high_port = r.port_b;
      end else begin
         res.key.low_addr  = r.addr_b;
         res.key.low_port  = r.port_b;
         res.key.high_addr = r.addr_a;
         res.key.high_port = r.port_a;
      end
      // key bytes taken from the little-endian layout
      mix = ({24'd0, res.key.low_addr[15:8]}  << SH_K1)
          ^ ({24'd0, res.key.low_addr[23:16]} << SH_K2)
          ^ ({24'd0, res.key.low_addr[31:24]} << SH_K3)
          ^ ({24'd0, res.key.low_port[7:0]}   << SH_K4)
          ^  {24'd0, res.key.low_port[15:8]};
      mix = mix * 32'(HASH_MULT);
      tail = {res.key.high_addr[23:16], res.key.high_addr[31:24],
              res.key.high_port[7:0], res.key.high_port[15:8]};
      res.flow_hash = mix ^ tail;
      // zero counts as one worker, counts above the maximum saturate
      n = 32'(wc);
      if (n == 0)
         n = 1;
      if (n > MAX_WORKERS)
         n = MAX_WORKERS;
      res.worker_index = WIDX_W'(res.flow_hash % n);
      return res;
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // every accepted request queues its prediction at the edge it is taken
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_steer_q.push_back(predict_steering(
            {req_chan.addr_a, req_chan.port_a, req_chan.addr_b, req_chan.port_b},
            worker_count_shadow));
      end
   end

   // every accepted response is matched against the oldest prediction
   always @(posedge clock) begin
      steer_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         responses_seen++;
         if (expected_steer_q.size() == 0) begin
            report_mismatch("unexpected response", {32'd0, rsp_chan.flow_hash}, 64'd0);
         end else begin
            want = expected_steer_q.pop_front();
            if (rsp_chan.low_addr !== want.key.low_addr)
               report_mismatch("low_addr", 64'(rsp_chan.low_addr), 64'(want.key.low_addr));
            if (rsp_chan.low_port !== want.key.low_port)
               report_mismatch("low_port", 64'(rsp_chan.low_port), 64'(want.key.low_port));
            if (rsp_chan.high_addr !== want.key.high_addr)
               report_mismatch("high_addr", 64'(rsp_chan.high_addr),
                               64'(want.key.high_addr));
            if (rsp_chan.high_port !== want.key.high_port)
               report_mismatch("high_port", 64'(rsp_chan.high_port),
                               64'(want.key.high_port));
            if (rsp_chan.flow_hash !== want.flow_hash)
               report_mismatch("flow_hash", 64'(rsp_chan.flow_hash), 64'(want.flow_hash));
            if (rsp_chan.worker_index !== want.worker_index)
               report_mismatch("worker_index", 64'(rsp_chan.worker_index),
                               64'(want.worker_index));
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_start) begin
            // hold the back end so the queue fills and the input stalls
            stall_start = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (STALL_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
         end
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.addr_a = '0;
      req_chan.port_a = '0;
      req_chan.addr_b = '0;
      req_chan.port_b = '0;
   end

   // offers one request and returns at the edge it is taken
   task automatic send_request(input flow_request_type r);
      while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.addr_a <= r.addr_a;
      req_chan.port_a <= r.port_a;
      req_chan.addr_b <= r.addr_b;
      req_chan.port_b <= r.port_b;
      if (r.addr_a == r.addr_b)
         tie_requests++;
      requests_sent++;
      do
         @(posedge clock);
      while (!req_chan.ready);
   endtask

   // drops valid and waits until every response is back and the pipe is quiet
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_steer_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the block drained
   task automatic write_worker_count(input logic [WC_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      worker_count_shadow = value;
      count_writes++;
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly random headers, with a good share of equal addresses so the
   // port tie-break is reached often, and some extreme values
   function automatic flow_request_type random_flow_request();
      flow_request_type r;
      int unsigned      mode;
      mode = $urandom_range(0, 9);
      r.addr_a = $urandom;
      r.port_a = PORT_W'($urandom);
      r.addr_b = $urandom;
      r.port_b = PORT_W'($urandom);
      case (mode)
         6, 7: r.addr_b = r.addr_a;
         8: begin
            // equal addresses, ports sharing one byte
            r.addr_b = r.addr_a;
            if ($urandom_range(0, 1))
               r.port_b[7:0] = r.port_a[7:0];
            else
               r.port_b[15:8] = r.port_a[15:8];
         end
         9: begin
            r.addr_a = pick_addr();
            r.addr_b = $urandom_range(0, 1) ? r.addr_a : pick_addr();
            if ($urandom_range(0, 2) == 0)
               r.port_b = r.port_a;   // identical endpoints when addresses match
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_random_batch(input int unsigned count);
      repeat (count) send_request(random_flow_request());
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // field extremes and ordering corner cases at the reset worker count
   task automatic test_directed_keys();
      send_request({32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000});
      send_request({32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff});
      send_request({32'h0000_0000, 16'hffff, 32'hffff_ffff, 16'h0000});
      send_request({32'hffff_ffff, 16'h0000, 32'h0000_0000, 16'hffff});
      // equal addresses: raw port order and host order disagree in the first pair
      send_request({32'h0a00_0001, 16'h0100, 32'h0a00_0001, 16'h0001});
      send_request({32'h0a00_0001, 16'h0001, 32'h0a00_0001, 16'h0100});
      send_request({32'hc0a8_0101, 16'h5000, 32'hc0a8_0101, 16'h5001});
      send_request({32'hc0a8_0101, 16'h50ff, 32'hc0a8_0101, 16'h5000});
      // identical endpoints
      send_request({32'h0a00_0001, 16'h5000, 32'h0a00_0001, 16'h5000});
      send_request({32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000});
      // addresses one bit apart, top and bottom
      send_request({32'h8000_0000, 16'h1234, 32'h0000_0000, 16'h4321});
      send_request({32'h0000_0001, 16'h1234, 32'h0000_0000, 16'h4321});
      // alternating bit patterns
      send_request({32'haaaa_aaaa, 16'haaaa, 32'h5555_5555, 16'h5555});
      send_request({32'h5555_5555, 16'h5555, 32'haaaa_aaaa, 16'haaaa});
      // low-key byte shifted to the top of the mix set, so the multiply wraps
      send_request({32'hffff_ffff, 16'hffff, 32'hffff_fffe, 16'h0000});
      send_request({32'h00ff_ff00, 16'hff00, 32'hff00_00ff, 16'h00ff});
      wait_drained();
   endtask

   // random traffic over a range of worker counts, zero and saturation included
   task automatic test_worker_count_sweep();
      logic [WC_W-1:0] counts [12];
      counts = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd7, 5'd8, 5'd13, 5'd15, 5'd16,
                 5'd17, 5'd31};
      foreach (counts[i]) begin
         write_worker_count(counts[i]);
         send_random_batch(SWEEP_ITEMS);
         wait_drained();
      end
   endtask

   // a long receiver hold-off fills the block and stalls its input
   task automatic test_output_backpressure();
      write_worker_count(WC_W'(MAX_WORKERS));
      stall_start = 1'b1;
      send_random_batch(STALL_ITEMS);
      wait_drained();
   endtask

   // no idling on either side: one request per cycle
   task automatic test_back_to_back();
      write_worker_count(5'd6);
      gaps_on = 1'b0;
      send_random_batch(BURST_ITEMS);
      wait_drained();
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_keys();
      test_worker_count_sweep();
      test_output_backpressure();
      test_back_to_back();

      $display("run covered %0d requests and %0d responses, %0d with equal addresses",
               requests_sent, responses_seen, tie_requests);
      $display("worker count written %0d times from 0 to 31, with a %0d-cycle output stall",
               count_writes, STALL_CYCLES);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d responses outstanding", expected_steer_q.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
